>>> design/flu_pkg.sv
// ----------------------------------------------------------------------------
// flu_pkg: shared types and constants of the float log unit
// Q30 polynomial constants, status codes, pipeline side-band type and the
// leading-zero count used to normalize subnormal arguments.
// ----------------------------------------------------------------------------
package flu_pkg;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DOMAIN = 2'd1;
    localparam logic [1:0] ST_ZERO   = 2'd2;
    localparam logic [1:0] ST_INF    = 2'd3;

    // Q30 constants
    localparam logic [29:0] Q30_C1     = 30'd715829486;
    localparam logic [29:0] Q30_C2     = 30'd429226147;
    localparam logic [29:0] Q30_C3     = 30'd321317241;
    localparam logic [29:0] Q30_LN2    = 30'd744261118;
    localparam logic [29:0] Q30_LOG10E = 30'd466320149;

    // mantissa split point (24-bit significand, hidden bit included)
    localparam logic [23:0] SPLIT_SIG = 24'hB504F3;

    // divider geometry: remainder below the 25-bit divisor, 29 quotient bits
    localparam int REM_W     = 25;
    localparam int QUO_W     = 29;
    localparam int DIV_STEPS = QUO_W;

    // side-band that travels with each word through the pipeline
    typedef struct packed {
        logic              valid;
        logic              op;
        logic [1:0]        status;
        logic signed [8:0] expo;
        logic              rneg;
    } side_t;

    // count leading zeros of a 23-bit fraction (23 when all zero)
    function automatic logic [4:0] lzc23(input logic [22:0] v);
        logic [4:0] n;
        n = 5'd23;
        for (int i = 0; i < 23; i++) begin
            if (v[i]) n = 5'(22 - i);
        end
        return n;
    endfunction

endpackage

>>> design/flu_div_cell.sv
// ----------------------------------------------------------------------------
// flu_div_cell: one restoring division step
// Shifts the partial remainder left, subtracts the divisor when it fits and
// shifts the resulting quotient bit in; hands everything to the next cell.
// ----------------------------------------------------------------------------
module flu_div_cell import flu_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [REM_W-1:0]    rem_in,
    input  logic [QUO_W-1:0]    quo_in,
    input  logic [REM_W-1:0]    div_in,
    input  side_t               side_in,
    output logic [REM_W-1:0]    rem_out,
    output logic [QUO_W-1:0]    quo_out,
    output logic [REM_W-1:0]    div_out,
    output side_t               side_out
);

    logic [REM_W:0]   trial;
    logic             fits;
    logic [REM_W-1:0] rem_next;
    logic [QUO_W-1:0] quo_next;
    logic [REM_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [REM_W-1:0] div_reg;
    side_t            side_reg;

    // compare and subtract one step
    always_comb begin
        trial    = {rem_in, 1'b0};
        fits     = (trial >= {1'b0, div_in});
        rem_next = fits ? REM_W'(trial - {1'b0, div_in}) : REM_W'(trial);
        quo_next = {quo_in[QUO_W-2:0], fits};
    end

    // advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            div_reg <= div_in;
        end
    end

    // advance side-band
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else if (en) begin
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;
    assign div_out  = div_reg;
    assign side_out = side_reg;

endmodule

>>> design/flu_divider.sv
// ----------------------------------------------------------------------------
// flu_divider: chain of restoring division cells
// Produces the 29-bit quotient of (|n| << 31) / d, one bit per cell.
// ----------------------------------------------------------------------------
module flu_divider import flu_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [REM_W-1:0] rem_in,
    input  logic [REM_W-1:0] div_in,
    input  side_t            side_in,
    output logic [QUO_W-1:0] quo_out,
    output side_t            side_out
);

    logic [REM_W-1:0] rem_w  [0:DIV_STEPS];
    logic [QUO_W-1:0] quo_w  [0:DIV_STEPS];
    logic [REM_W-1:0] div_w  [0:DIV_STEPS];
    side_t            side_w [0:DIV_STEPS];

    assign rem_w[0]  = rem_in;
    assign quo_w[0]  = '0;
    assign div_w[0]  = div_in;
    assign side_w[0] = side_in;

    // build the row of cells
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
        flu_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .rem_in   (rem_w[i]),
            .quo_in   (quo_w[i]),
            .div_in   (div_w[i]),
            .side_in  (side_w[i]),
            .rem_out  (rem_w[i+1]),
            .quo_out  (quo_w[i+1]),
            .div_out  (div_w[i+1]),
            .side_out (side_w[i+1])
        );
    end

    assign quo_out  = quo_w[DIV_STEPS];
    assign side_out = side_w[DIV_STEPS];

endmodule

>>> design/float_log_unit_top.sv
// Pipeline: 2 front stages, 29 division cells, 8 polynomial stages and 1 output
// register lie between the input word and the result word.
// Throughput: one word per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, so the 29-cell divider sets depth.
// Reset: aresetn synchronous, active low; clears all valid flags, no
// clearing pass, input ready right after reset.
// ----------------------------------------------------------------------------
// float_log_unit_top: pipelined fixed-point logarithm of a single float
// Normalizes the argument, forms r=(m-1)/(m+1) in a divider cell chain and
// evaluates the odd polynomial with optional base-10 scaling.
// ----------------------------------------------------------------------------
module float_log_unit_top import flu_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value_bits
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] log_value
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int SH = 30 - FRAC_BITS;
    localparam logic [66:0] HALF67 = 67'(1) << 29;

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: classify and count leading zeros ------------
    side_t       s1_side_next, s1_side_reg;
    logic [7:0]  s1_ef_reg;
    logic [22:0] s1_frac_reg;
    logic [4:0]  s1_shift_reg;

    always_comb begin
        logic       neg;
        logic [7:0] ef;
        logic [22:0] fr;
        neg = s_tdata[31];
        ef  = s_tdata[30:23];
        fr  = s_tdata[22:0];
        s1_side_next       = '0;
        s1_side_next.valid = s_tvalid;
        s1_side_next.op    = s_tuser[0];
        if (ef == 8'hFF && fr != '0)      s1_side_next.status = ST_DOMAIN;
        else if (ef == 8'h00 && fr == '0) s1_side_next.status = ST_ZERO;
        else if (neg)                     s1_side_next.status = ST_DOMAIN;
        else if (ef == 8'hFF)             s1_side_next.status = ST_INF;
        else                              s1_side_next.status = ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_side_reg <= '0;
        end else if (adv) begin
            s1_side_reg <= s1_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ef_reg    <= s_tdata[30:23];
            s1_frac_reg  <= s_tdata[22:0];
            s1_shift_reg <= lzc23(s_tdata[22:0]) + 5'd1;
        end
    end

    // ---------------- stage 2: normalize and split mantissa ----------------
    side_t            s2_side_next, s2_side_reg;
    logic [REM_W-1:0] s2_rem_next, s2_rem_reg;
    logic [REM_W-1:0] s2_div_next, s2_div_reg;

    always_comb begin
        logic [23:0]       sig;
        logic signed [8:0] e0;
        logic              hi;
        logic [22:0]       nmag;
        if (s1_ef_reg == 8'h00) begin
            sig = 24'(s1_frac_reg) << s1_shift_reg;
            e0  = -9'sd126 - $signed({4'b0, s1_shift_reg});
        end else begin
            sig = {1'b1, s1_frac_reg};
            e0  = $signed({1'b0, s1_ef_reg}) - 9'sd127;
        end
        hi   = (sig > SPLIT_SIG);
        nmag = hi ? 23'(25'h1000000 - 25'(sig)) : 23'(sig - 24'h800000);
        s2_div_next = hi ? (25'(sig) + 25'h1000000) : (25'(sig) + 25'h0800000);
        s2_rem_next = {nmag, 2'b00};
        s2_side_next      = s1_side_reg;
        s2_side_next.expo = e0 + $signed({8'b0, hi});
        s2_side_next.rneg = hi;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_side_reg <= '0;
        end else if (adv) begin
            s2_side_reg <= s2_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_rem_reg <= s2_rem_next;
            s2_div_reg <= s2_div_next;
        end
    end

    // ---------------- divider cell chain -----------------------------------
    logic [QUO_W-1:0] dv_quo;
    side_t            dv_side;

    flu_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .rem_in   (s2_rem_reg),
        .div_in   (s2_div_reg),
        .side_in  (s2_side_reg),
        .quo_out  (dv_quo),
        .side_out (dv_side)
    );

    // ---------------- polynomial pipeline ----------------------------------
    side_t              p1_side_reg, p2_side_reg, p3_side_reg, p4_side_reg;
    side_t              p5_side_reg, p6_side_reg, p7_side_reg, p8_side_reg;
    logic [27:0]        p1_rmag_reg, p2_rmag_reg, p3_rmag_reg, p4_rmag_reg;
    logic [27:0]        p5_rmag_reg;
    logic signed [37:0] p1_eln_reg, p2_eln_reg, p3_eln_reg, p4_eln_reg;
    logic signed [37:0] p5_eln_reg;
    logic [25:0]        p2_r2_reg, p3_r2_reg, p3_t1_reg;
    logic [23:0]        p3_r3_reg, p4_r3_reg;
    logic [25:0]        p4_t2_reg;
    logic [23:0]        p5_term_reg;
    logic signed [38:0] p6_total_reg, p7_total_reg, p8_fin_reg;
    logic               p7_tneg_reg;
    logic [51:0]        p7_hil_reg;
    logic [43:0]        p7_lol_reg;

    logic [27:0]        p1_rmag_next;
    logic signed [37:0] p1_eln_next;
    logic [25:0]        p2_r2_next, p3_t1_next, p4_t2_next;
    logic [23:0]        p3_r3_next, p5_term_next;
    logic signed [38:0] p6_total_next, p8_fin_next;
    logic               p7_tneg_next;
    logic [51:0]        p7_hil_next;
    logic [43:0]        p7_lol_next;

    // round the quotient and scale the exponent by ln2
    always_comb begin
        p1_rmag_next = 28'((30'(dv_quo) + 30'd1) >> 1);
        p1_eln_next  = 38'(dv_side.expo) * $signed(38'(Q30_LN2));
    end

    // r^2
    assign p2_r2_next = 26'((56'(p1_rmag_reg) * 56'(p1_rmag_reg) + (56'(1) << 29)) >> 30);

    // r^3 and r^2*c3
    always_comb begin
        p3_r3_next = 24'((54'(p2_rmag_reg) * 54'(p2_r2_reg) + (54'(1) << 29)) >> 30);
        p3_t1_next = 26'((56'(p2_r2_reg) * 56'(Q30_C3) + (56'(1) << 29)) >> 30);
    end

    // r^2*(c2 + r^2*c3)
    assign p4_t2_next = 26'((56'(p3_r2_reg) * 56'(30'(Q30_C2) + 30'(p3_t1_reg))
                            + (56'(1) << 29)) >> 30);

    // r^3*(c1 + ...)
    assign p5_term_next = 24'((54'(30'(Q30_C1) + 30'(p4_t2_reg)) * 54'(p4_r3_reg)
                              + (54'(1) << 29)) >> 30);

    // sum the natural log
    always_comb begin
        logic [29:0]        mag;
        logic signed [38:0] smag;
        mag  = 30'({p5_rmag_reg, 1'b0}) + 30'(p5_term_reg);
        smag = $signed(39'(mag));
        if (p5_side_reg.rneg) smag = -smag;
        p6_total_next = smag + 39'(p5_eln_reg);
    end

    // split |total| * log10(e) into two partial products
    always_comb begin
        logic [37:0] tmag;
        p7_tneg_next = p6_total_reg[38];
        tmag         = 38'(p7_tneg_next ? -p6_total_reg : p6_total_reg);
        p7_hil_next  = 52'(tmag[37:15]) * 52'(Q30_LOG10E);
        p7_lol_next  = 44'(tmag[14:0]) * 44'(Q30_LOG10E);
    end

    // combine partial products and pick the mode
    always_comb begin
        logic [36:0]        pm;
        logic signed [38:0] sp;
        pm = 37'(({p7_hil_reg, 15'b0} + 67'(p7_lol_reg) + HALF67) >> 30);
        sp = $signed(39'(pm));
        if (p7_tneg_reg) sp = -sp;
        p8_fin_next = p7_side_reg.op ? sp : p7_total_reg;
    end

    // advance side-bands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_side_reg <= '0;
            p2_side_reg <= '0;
            p3_side_reg <= '0;
            p4_side_reg <= '0;
            p5_side_reg <= '0;
            p6_side_reg <= '0;
            p7_side_reg <= '0;
            p8_side_reg <= '0;
        end else if (adv) begin
            p1_side_reg <= dv_side;
            p2_side_reg <= p1_side_reg;
            p3_side_reg <= p2_side_reg;
            p4_side_reg <= p3_side_reg;
            p5_side_reg <= p4_side_reg;
            p6_side_reg <= p5_side_reg;
            p7_side_reg <= p6_side_reg;
            p8_side_reg <= p7_side_reg;
        end
    end

    // advance payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_rmag_reg  <= p1_rmag_next;
            p1_eln_reg   <= p1_eln_next;
            p2_rmag_reg  <= p1_rmag_reg;
            p2_eln_reg   <= p1_eln_reg;
            p2_r2_reg    <= p2_r2_next;
            p3_rmag_reg  <= p2_rmag_reg;
            p3_eln_reg   <= p2_eln_reg;
            p3_r2_reg    <= p2_r2_reg;
            p3_r3_reg    <= p3_r3_next;
            p3_t1_reg    <= p3_t1_next;
            p4_rmag_reg  <= p3_rmag_reg;
            p4_eln_reg   <= p3_eln_reg;
            p4_r3_reg    <= p3_r3_reg;
            p4_t2_reg    <= p4_t2_next;
            p5_rmag_reg  <= p4_rmag_reg;
            p5_eln_reg   <= p4_eln_reg;
            p5_term_reg  <= p5_term_next;
            p6_total_reg <= p6_total_next;
            p7_total_reg <= p6_total_reg;
            p7_tneg_reg  <= p7_tneg_next;
            p7_hil_reg   <= p7_hil_next;
            p7_lol_reg   <= p7_lol_next;
            p8_fin_reg   <= p8_fin_next;
        end
    end

    // ---------------- output: round, saturate, apply status ----------------
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg;

    always_comb begin
        logic        fneg;
        logic [38:0] fmag;
        logic [38:0] rm;
        fneg = p8_fin_reg[38];
        fmag = 39'(fneg ? -p8_fin_reg : p8_fin_reg);
        rm   = (fmag + (39'(1) << (SH - 1))) >> SH;
        if (!fneg && rm > 39'h7FFFFFFF)     m_tdata_next = 32'h7FFFFFFF;
        else if (fneg && rm > 39'h80000000) m_tdata_next = 32'h80000000;
        else if (fneg)                      m_tdata_next = 32'(-rm);
        else                                m_tdata_next = 32'(rm);
        case (p8_side_reg.status)
            ST_OK:     ;
            ST_ZERO:   m_tdata_next = 32'h80000000;
            ST_INF:    m_tdata_next = 32'h7FFFFFFF;
            default:   m_tdata_next = 32'h0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= p8_side_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= p8_side_reg.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions -------------------------------------------
    a_last_stage_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && p8_side_reg.valid |=> m_tvalid)
        else $error("valid word in last stage did not reach output");

    a_zero_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_ZERO |-> m_tdata == 32'h80000000)
        else $error("zero input must give most negative result");

    a_domain_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_DOMAIN |-> m_tdata == 32'h0)
        else $error("domain error must give zero result");

    a_inf_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_INF |-> m_tdata == 32'h7FFFFFFF)
        else $error("infinite input must saturate to maximum");

endmodule
